// ----- rtl/core/osr_pkg.sv -----
// osr_pkg: shared constants, opcodes and control structs of the outline shape rasterizer
// no dependencies
package osr_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 32;
  localparam int ROW_AW      = $clog2(MAX_ROWS);
  localparam int COL_AW      = $clog2(MAX_COLUMNS);

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_RECT  = 3'd1;
  localparam logic [2:0] OP_CIRC  = 3'd2;
  localparam logic [2:0] OP_TRI   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // control strobes from the sequencer to the datapath
  typedef struct packed {
    logic       load;      // latch command fields
    logic       clr_row;   // clear row at sweep counter
    logic       step;      // run one pixel visit
    logic       rd_row;    // latch read data as result
  } osr_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic draw_done;
  } osr_sts_t;

endpackage

// ----- rtl/core/osr_ctrl.sv -----
// osr_ctrl: command sequencer of the rasterizer
// depends on osr_pkg
module osr_ctrl import osr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [2:0] in_op,
  input  osr_sts_t   sts,
  input  logic       out_busy,
  output logic       idle,
  output osr_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CLR  = 2'd1;
  localparam logic [1:0] S_DRAW = 2'd2;

  logic [1:0] state, state_next;

  assign idle = (state == S_IDLE) && !out_busy;

  // command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          if (in_op == OP_CLEAR) state_next = S_CLR;
          else if (in_op == OP_RECT || in_op == OP_CIRC || in_op == OP_TRI)
            state_next = S_DRAW;
          else if (in_op == OP_READ) cmd.rd_row = 1'b1;
        end
      end
      S_CLR: begin
        cmd.clr_row = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_DRAW: begin
        cmd.step = 1'b1;
        if (sts.draw_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ----- rtl/core/osr_dp.sv -----
// osr_dp: frame store and pixel walker of the rasterizer
// depends on osr_pkg
module osr_dp import osr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  osr_cmd_t    cmd,
  input  logic [2:0]  in_op,
  input  logic [8:0]  in_x,
  input  logic [8:0]  in_y,
  input  logic [7:0]  in_a,
  input  logic [7:0]  in_b,
  input  logic [4:0]  in_row,
  input  logic [6:0]  lim_w,
  input  logic [5:0]  lim_h,
  output osr_sts_t    sts,
  output logic [63:0] rd_data
);

  // frame rows with valid bits; invalid rows read blank
  logic [MAX_COLUMNS-1:0] frame [MAX_ROWS];
  logic [MAX_ROWS-1:0]    vld;

  logic [2:0]        op;
  logic signed [9:0] x, y;
  logic [7:0]        a, b;
  // walker counters: i outer, j inner
  logic signed [9:0] i, j;
  logic [1:0]        phase;
  logic [ROW_AW-1:0] clr_cnt;

  // triangle division unit (restoring, 16 steps)
  logic [15:0] dq, prod;
  logic [8:0]  drem;
  logic [4:0]  dcnt;
  logic        dbusy;

  // candidate pixel and ink enable
  logic signed [10:0] pc, pr;
  logic               pen, last;
  logic signed [10:0] dd;
  logic [17:0]        sq;
  logic [18:0]        lo, hi;

  always_comb begin
    pc = '0; pr = '0; pen = 1'b0; last = 1'b0;
    sq = 18'((j * j) + (i * i));
    lo = 19'(a * a) - 19'(a);
    hi = 19'(a * a) + 19'(a);
    dd = '0;
    unique case (op)
      OP_RECT: begin
        // phase 0,1: horizontal edges over j; phase 2,3: vertical edges
        if (phase[1] == 1'b0) begin
          pc  = 11'(x) + 11'(j);
          pr  = phase[0] ? 11'(y) + 11'(b) - 11'sd1 : 11'(y);
          pen = j < $signed({2'b0, a});
        end else begin
          pc  = phase[0] ? 11'(x) + 11'(a) - 11'sd1 : 11'(x);
          pr  = 11'(y) + 11'(j);
          pen = j < $signed({2'b0, b});
        end
        last = (phase == 2'd3) && (j >= $signed({2'b0, b}) - 10'sd1);
      end
      OP_CIRC: begin
        pc  = 11'(x) + 11'(j);
        pr  = 11'(y) + 11'(i);
        pen = {1'b0, sq} >= lo && {1'b0, sq} <= hi;
        last = (i == $signed({2'b0, a})) && (j == $signed({2'b0, a}));
      end
      OP_TRI: begin
        if (phase != 2'd2) begin
          dd  = 11'(dq[15:1]);
          pc  = phase[0] ? 11'(x) + dd : 11'(x) - dd;
          pr  = 11'(y) + 11'(i);
          pen = !dbusy && i < $signed({2'b0, b});
        end else begin
          pc  = 11'(x) - 11'(a[7:1]) + 11'(j);
          pr  = 11'(y) + 11'(b) - 11'sd1;
          pen = j <= $signed({2'b0, a[7:1], 1'b0});
          last = !pen;
        end
      end
      default: ;
    endcase
  end

  logic inb;
  assign inb = pen && pc >= 0 && pc < 11'(lim_w) && pr >= 0 && pr < 11'(lim_h);

  assign sts.clr_done  = (clr_cnt == ROW_AW'(MAX_ROWS - 1));
  assign sts.draw_done = cmd.step && last;

  // walker sequencing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op; x <= 10'(signed'(in_x)); y <= 10'(signed'(in_y));
      a <= in_a; b <= in_b; phase <= '0; clr_cnt <= '0;
      j <= (in_op == OP_CIRC) ? -$signed({2'b0, in_a}) : '0;
      i <= (in_op == OP_CIRC) ? -$signed({2'b0, in_a}) : '0;
      dbusy <= 1'b1; dcnt <= '0; drem <= '0; dq <= '0;
      prod <= '0;
    end else if (cmd.clr_row) begin
      clr_cnt <= clr_cnt + 1'b1;
    end else if (cmd.step) begin
      unique case (op)
        OP_RECT: begin
          if (j >= $signed({2'b0, (phase[1] ? b : a)}) - 10'sd1 ||
              (phase[1] ? b : a) == 8'd0) begin
            j <= '0; phase <= phase + 1'b1;
          end else j <= j + 10'sd1;
        end
        OP_CIRC: begin
          if (j == $signed({2'b0, a})) begin
            j <= -$signed({2'b0, a}); i <= i + 10'sd1;
          end else j <= j + 10'sd1;
        end
        OP_TRI: begin
          if (phase == 2'd2) j <= j + 10'sd1;
          else if (dbusy) begin
            // long division of prod by b, one quotient bit a cycle
            if (b == 8'd0) begin
              dbusy <= 1'b0; phase <= 2'd2; j <= '0;
            end else begin
              drem <= ({drem[7:0], prod[4'd15 - dcnt[3:0]]} >= {1'b0, b}) ?
                      {drem[7:0], prod[4'd15 - dcnt[3:0]]} - {1'b0, b} :
                      {drem[7:0], prod[4'd15 - dcnt[3:0]]};
              dq   <= {dq[14:0],
                      ({drem[7:0], prod[4'd15 - dcnt[3:0]]} >= {1'b0, b})};
              dcnt <= dcnt + 1'b1;
              if (dcnt == 5'd15) dbusy <= 1'b0;
            end
          end else if (phase == 2'd0) phase <= 2'd1;
          else begin
            if (i + 10'sd1 >= $signed({2'b0, b})) begin
              phase <= 2'd2; j <= '0;
            end else begin
              phase <= 2'd0; i <= i + 10'sd1;
              prod <= prod + 16'(a);
              dbusy <= 1'b1; dcnt <= '0; drem <= '0; dq <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // frame store: read-modify-write one pixel a cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_row) begin
      frame[clr_cnt] <= '0;
    end else if (cmd.step && inb) begin
      frame[pr[ROW_AW-1:0]] <= (vld[pr[ROW_AW-1:0]] ? frame[pr[ROW_AW-1:0]] : '0) |
                               (MAX_COLUMNS'(1) << pc[COL_AW-1:0]);
    end
    if (cmd.rd_row)
      rd_data <= (vld[in_row[ROW_AW-1:0]] ? frame[in_row[ROW_AW-1:0]] : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (cmd.clr_row) vld[clr_cnt] <= 1'b1;
    else if (cmd.step && inb) vld[pr[ROW_AW-1:0]] <= 1'b1;
  end

endmodule

// ----- rtl/core/outline_shape_rasterizer.sv -----
// outline_shape_rasterizer: top level, stream ports, config registers, output register
// depends on osr_pkg, osr_ctrl, osr_dp
// read row: the row is latched into rd_data, then into the output register; clear sweeps
// every row of the frame store; draws step through the outline pixels by read-modify-write
// of the frame store, and each triangle row waits for the divider
// one command at a time; reset blanks the frame at once and loads width 58, height 32
module outline_shape_rasterizer import osr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // op[2:0], pos_x[11:3], pos_y[20:12], size_a[28:21],
                                // size_b[36:29], row_index[41:37], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // row_bits[63:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [6:0] act_w;
  logic [5:0] act_h;
  logic [6:0] lim_w;
  logic [5:0] lim_h;
  logic       idle, in_fire, rd_pend;
  osr_cmd_t   cmd;
  osr_sts_t   sts;
  logic [63:0] rd_data;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      act_w <= 7'd58; act_h <= 6'd32;
    end else if (cfg_we) begin
      if (cfg_index) act_h <= cfg_data[5:0];
      else           act_w <= cfg_data;
    end
  end
  assign lim_w = (act_w > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : act_w;
  assign lim_h = (act_h > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : act_h;

  assign s_tready = idle;
  assign in_fire  = s_tvalid && s_tready;

  osr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_op(s_tdata[2:0]), .sts(sts),
    .out_busy(rd_pend || m_tvalid), .idle(idle), .cmd(cmd)
  );

  osr_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_op(s_tdata[2:0]), .in_x(s_tdata[11:3]),
    .in_y(s_tdata[20:12]), .in_a(s_tdata[28:21]), .in_b(s_tdata[36:29]),
    .in_row(s_tdata[41:37]), .lim_w(lim_w), .lim_h(lim_h), .sts(sts),
    .rd_data(rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0; m_tvalid <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_row;
      if (rd_pend) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
    if (rd_pend) m_tdata <= rd_data;
  end

  a_one_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_row |=> rd_pend) else $error("read not staged");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accept while result pending");
  a_clr_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_row && cmd.step)) else $error("clear and draw together");

endmodule
